FILE: design/llqs_pkg.sv
// Shared types and constants for the linked queue pair block.
`default_nettype none
package llqs_pkg;

  localparam int NODE_COUNT_DEF = 256;
  localparam int DATA_W         = 32;

  typedef enum logic [1:0] {
    REQ_ENQ = 2'd0,
    REQ_DEQ = 2'd1,
    REQ_CAT = 2'd2
  } req_kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage
`default_nettype wire

FILE: design/llqs_if.sv
// Request and response channel interfaces.
`default_nettype none
interface llqs_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic               queue_sel;
  logic signed [31:0] value;

  modport source (output valid, req_type, queue_sel, value, input ready);
  modport sink   (input valid, req_type, queue_sel, value, output ready);
endinterface

interface llqs_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] data;
  logic [1:0]         status;

  modport source (output valid, data, status, input ready);
  modport sink   (input valid, data, status, output ready);
endinterface
`default_nettype wire

FILE: design/llqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module llqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire  [$clog2(DEPTH)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]         wr_data,
  input  wire                      rd_en,
  input  wire  [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: design/linked_queue_pair_with_splice.sv
// Two linked-list FIFO queues in a shared node pool, with constant-time splice.
//
// Channels: req carries one word per request (req_type, queue_sel, value);
// rsp returns exactly one word per request (data, status), in order.
// Request kinds: enqueue onto the selected queue, dequeue its head, or splice
// the other queue onto its tail (the other queue is left empty).
// Timing: a request is taken in the idle cycle, the node memories are read at
// that edge, and the exec state then does the update and loads the response
// register; the update waits for the registered read of the link memory.
// req.ready is high only in the idle cycle.
// If rsp is stalled, the response register holds its word and the update
// cycle waits until the register is free; a new request can be taken while a
// finished response still waits.
// Reset (synchronous, rst high) empties both queues and the free list and
// restarts fresh node allocation; no memory clearing pass is needed since a
// node is always written before it is read.
`default_nettype none
module linked_queue_pair_with_splice
  import llqs_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  wire         clk,
  input  wire         rst,
  llqs_req_if.sink    req,
  llqs_rsp_if.source  rsp
);

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int CNT_W = $clog2(NODE_COUNT + 1);

  state_t state, state_next;

  logic [IDX_W-1:0] queue_head [2];
  logic [IDX_W-1:0] queue_tail [2];
  logic [1:0]       queue_nonempty;
  logic [IDX_W-1:0] free_head;
  logic             free_nonempty;
  logic [CNT_W-1:0] fresh_count;

  logic [IDX_W-1:0] queue_head_next [2];
  logic [IDX_W-1:0] queue_tail_next [2];
  logic [1:0]       queue_nonempty_next;
  logic [IDX_W-1:0] free_head_next;
  logic             free_nonempty_next;
  logic [CNT_W-1:0] fresh_count_next;

  // latched request
  req_kind_t          kind;
  logic               sel;
  logic signed [31:0] value;

  logic               out_valid;
  logic signed [31:0] out_data;
  status_t            out_status;
  logic signed [31:0] out_data_next;
  status_t            out_status_next;

  logic accept;
  logic go;

  // memory ports
  logic              val_wr_en;
  logic [IDX_W-1:0]  val_wr_addr;
  logic [DATA_W-1:0] val_rd_data;
  logic [IDX_W-1:0]  val_rd_addr;
  logic              lnk_wr_en;
  logic [IDX_W-1:0]  lnk_wr_addr;
  logic [IDX_W-1:0]  lnk_wr_data;
  logic [IDX_W-1:0]  lnk_rd_addr;
  logic [IDX_W-1:0]  lnk_rd_data;

  logic             oth;
  logic [IDX_W-1:0] node;

  assign req.ready  = (state == ST_IDLE);
  assign accept     = req.valid && req.ready;
  assign go         = (state == ST_EXEC) && (!out_valid || rsp.ready);
  assign rsp.valid  = out_valid;
  assign rsp.data   = out_data;
  assign rsp.status = out_status;
  assign oth        = ~sel;

  // read addresses come straight from the incoming word
  assign val_rd_addr = queue_head[req.queue_sel];
  assign lnk_rd_addr = (req_kind_t'(req.req_type) == REQ_ENQ) ? free_head
                                                               : queue_head[req.queue_sel];

  llqs_ram #(.WIDTH(DATA_W), .DEPTH(NODE_COUNT)) u_value_ram (
    .clk     (clk),
    .wr_en   (val_wr_en),
    .wr_addr (val_wr_addr),
    .wr_data (value),
    .rd_en   (accept),
    .rd_addr (val_rd_addr),
    .rd_data (val_rd_data)
  );

  llqs_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_link_ram (
    .clk     (clk),
    .wr_en   (lnk_wr_en),
    .wr_addr (lnk_wr_addr),
    .wr_data (lnk_wr_data),
    .rd_en   (accept),
    .rd_addr (lnk_rd_addr),
    .rd_data (lnk_rd_data)
  );

  always_comb begin
    state_next          = state;
    queue_head_next     = queue_head;
    queue_tail_next     = queue_tail;
    queue_nonempty_next = queue_nonempty;
    free_head_next      = free_head;
    free_nonempty_next  = free_nonempty;
    fresh_count_next    = fresh_count;
    out_data_next       = '0;
    out_status_next     = STAT_OK;
    val_wr_en           = 1'b0;
    val_wr_addr         = '0;
    lnk_wr_en           = 1'b0;
    lnk_wr_addr         = '0;
    lnk_wr_data         = '0;
    node                = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (go) begin
          state_next = ST_IDLE;
          unique case (kind)
            REQ_ENQ: begin
              if (free_nonempty || (fresh_count < CNT_W'(NODE_COUNT))) begin
                if (free_nonempty) begin
                  node = free_head;
                  // last free node links to itself
                  if (lnk_rd_data == free_head) begin
                    free_nonempty_next = 1'b0;
                  end else begin
                    free_head_next = lnk_rd_data;
                  end
                end else begin
                  node             = fresh_count[IDX_W-1:0];
                  fresh_count_next = fresh_count + CNT_W'(1);
                end
                val_wr_en   = 1'b1;
                val_wr_addr = node;
                if (queue_nonempty[sel]) begin
                  lnk_wr_en   = 1'b1;
                  lnk_wr_addr = queue_tail[sel];
                  lnk_wr_data = node;
                end else begin
                  queue_head_next[sel]     = node;
                  queue_nonempty_next[sel] = 1'b1;
                end
                queue_tail_next[sel] = node;
              end else begin
                out_status_next = STAT_FULL;
              end
            end
            REQ_DEQ: begin
              if (!queue_nonempty[sel]) begin
                out_status_next = STAT_EMPTY;
              end else begin
                node          = queue_head[sel];
                out_data_next = val_rd_data;
                if (node == queue_tail[sel]) begin
                  queue_nonempty_next[sel] = 1'b0;
                end else begin
                  queue_head_next[sel] = lnk_rd_data;
                end
                lnk_wr_en          = 1'b1;
                lnk_wr_addr        = node;
                lnk_wr_data        = free_nonempty ? free_head : node;
                free_head_next     = node;
                free_nonempty_next = 1'b1;
              end
            end
            REQ_CAT: begin
              if (queue_nonempty[oth]) begin
                if (queue_nonempty[sel]) begin
                  lnk_wr_en   = 1'b1;
                  lnk_wr_addr = queue_tail[sel];
                  lnk_wr_data = queue_head[oth];
                end else begin
                  queue_head_next[sel]     = queue_head[oth];
                  queue_nonempty_next[sel] = 1'b1;
                end
                queue_tail_next[sel]     = queue_tail[oth];
                queue_nonempty_next[oth] = 1'b0;
              end
            end
            default: begin
              // unused request code: no change
            end
          endcase
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      queue_head     <= '{default: '0};
      queue_tail     <= '{default: '0};
      queue_nonempty <= '0;
      free_head      <= '0;
      free_nonempty  <= 1'b0;
      fresh_count    <= '0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      queue_head     <= queue_head_next;
      queue_tail     <= queue_tail_next;
      queue_nonempty <= queue_nonempty_next;
      free_head      <= free_head_next;
      free_nonempty  <= free_nonempty_next;
      fresh_count    <= fresh_count_next;
      if (go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind  <= req_kind_t'(req.req_type);
      sel   <= req.queue_sel;
      value <= req.value;
    end
    if (go) begin
      out_data   <= out_data_next;
      out_status <= out_status_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/llqs_checker.sv
// Port-level checks for the linked queue pair block, bound to the top level.
`default_nettype none
module llqs_port_checks
  import llqs_pkg::*;
(
  input wire        clk,
  input wire        rst,
  input wire        req_valid,
  input wire        req_ready,
  input wire        rsp_valid,
  input wire        rsp_ready,
  input wire [31:0] rsp_data,
  input wire [1:0]  rsp_status
);

  // one request at a time: ready drops after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one still in progress");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_status))
    else $error("stalled response word changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == STAT_OK) || (rsp_status == STAT_EMPTY)
                  || (rsp_status == STAT_FULL))
    else $error("bad status code");

  // data is only carried by a successful dequeue
  a_data_ok_only: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data != 32'd0) |-> rsp_status == STAT_OK)
    else $error("data returned with error status");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind linked_queue_pair_with_splice llqs_port_checks u_llqs_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_data   (rsp.data),
  .rsp_status (rsp.status)
);
`default_nettype wire
